// File: src/button_map_edge_accumulator_macros.svh
// Assertion helpers used by the checker in src/bmea_checker.sv.
`ifndef BUTTON_MAP_EDGE_ACCUMULATOR_MACROS_SVH
`define BUTTON_MAP_EDGE_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define BMEA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define BMEA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bmea_pkg.sv
package bmea_pkg;

    localparam int MAX_PORTS = 2;
    localparam int ACT_IDX_W = 4;
    localparam int LEVEL_W = 10;
    localparam int HIT_COUNT = 4;
    localparam int COUNT_W = 16;
    localparam int ADD_W = 6;
    localparam int RAW_W = 32;
    localparam int HIGH_SHIFT = 16;

    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_CONSUME = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;

    localparam logic [ACT_IDX_W-1:0] ACT_HIT_SL = 4'd0;
    localparam logic [ACT_IDX_W-1:0] ACT_HIT_CL = 4'd1;
    localparam logic [ACT_IDX_W-1:0] ACT_HIT_CR = 4'd2;
    localparam logic [ACT_IDX_W-1:0] ACT_HIT_SR = 4'd3;
    localparam logic [ACT_IDX_W-1:0] ACT_ENTER = 4'd4;
    localparam logic [ACT_IDX_W-1:0] ACT_SERVICE = 4'd5;
    localparam logic [ACT_IDX_W-1:0] ACT_TEST = 4'd6;
    localparam logic [ACT_IDX_W-1:0] ACT_COIN = 4'd7;
    localparam logic [ACT_IDX_W-1:0] ACT_UP = 4'd8;
    localparam logic [ACT_IDX_W-1:0] ACT_DOWN = 4'd9;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam logic [RAW_W-1:0] BTN_SELECT = 32'h0000_0001;
    localparam logic [RAW_W-1:0] BTN_L3 = 32'h0000_0002;
    localparam logic [RAW_W-1:0] BTN_R3 = 32'h0000_0004;
    localparam logic [RAW_W-1:0] BTN_START = 32'h0000_0008;
    localparam logic [RAW_W-1:0] BTN_UP = 32'h0000_0010;
    localparam logic [RAW_W-1:0] BTN_RIGHT = 32'h0000_0020;
    localparam logic [RAW_W-1:0] BTN_DPAD_DOWN = 32'h0000_0040;
    localparam logic [RAW_W-1:0] BTN_LEFT = 32'h0000_0080;
    localparam logic [RAW_W-1:0] BTN_L2 = 32'h0000_0001 << HIGH_SHIFT;
    localparam logic [RAW_W-1:0] BTN_R2 = 32'h0000_0002 << HIGH_SHIFT;
    localparam logic [RAW_W-1:0] BTN_L1 = 32'h0000_0004 << HIGH_SHIFT;
    localparam logic [RAW_W-1:0] BTN_R1 = 32'h0000_0008 << HIGH_SHIFT;
    localparam logic [RAW_W-1:0] BTN_TRIANGLE = 32'h0000_0010 << HIGH_SHIFT;
    localparam logic [RAW_W-1:0] BTN_CIRCLE = 32'h0000_0020 << HIGH_SHIFT;
    localparam logic [RAW_W-1:0] BTN_CROSS = 32'h0000_0040 << HIGH_SHIFT;
    localparam logic [RAW_W-1:0] BTN_SQUARE = 32'h0000_0080 << HIGH_SHIFT;

    typedef struct packed {
        logic sample;
        logic write;
        logic consume;
    } bmea_ctl_t;

    function automatic logic [RAW_W-1:0] default_binding(input logic [ACT_IDX_W-1:0] act);
        logic [RAW_W-1:0] m;
        case (act)
            ACT_HIT_SL:  m = BTN_LEFT | BTN_UP | BTN_L1 | BTN_L2;
            ACT_HIT_CL:  m = BTN_RIGHT | BTN_DPAD_DOWN;
            ACT_HIT_CR:  m = BTN_SQUARE | BTN_CROSS;
            ACT_HIT_SR:  m = BTN_TRIANGLE | BTN_CIRCLE | BTN_R1 | BTN_R2;
            ACT_ENTER:   m = BTN_START;
            ACT_SERVICE: m = BTN_R3;
            ACT_TEST:    m = BTN_SELECT;
            ACT_COIN:    m = BTN_L3;
            ACT_UP:      m = BTN_UP;
            ACT_DOWN:    m = BTN_DPAD_DOWN;
            default:     m = '0;
        endcase
        return m;
    endfunction

    // Pairwise adder tree, five levels deep for a 32-bit word.
    function automatic logic [ADD_W-1:0] popcount32(input logic [RAW_W-1:0] v);
        logic [ADD_W-1:0] part [RAW_W];
        for (int i = 0; i < RAW_W; i++)
        begin
            part[i] = ADD_W'(v[i]);
        end
        for (int w = RAW_W >> 1; w > 0; w = w >> 1)
        begin
            for (int i = 0; i < w; i++)
            begin
                part[i] = part[2 * i] + part[2 * i + 1];
            end
        end
        return part[0];
    endfunction

endpackage

// File: src/button_map_edge_accumulator.sv
// A consume beat goes through the input register, then into the output register.
// Throughput: one item per cycle; the input stalls only while a consume sits in the
// input register and the output register holds a result that is itself stalled.
// Reset clears all levels, hit flags, previous raw words and counters at once and
// restores the default button bindings; the block accepts items right after reset.
module button_map_edge_accumulator #(
    parameter int PORT_COUNT = 2,
    parameter int ACTION_COUNT = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          func,
    input  logic                                port,
    input  logic                                sample_valid,
    input  logic [bmea_pkg::RAW_W-1:0]          raw_buttons,
    input  logic [bmea_pkg::ACT_IDX_W-1:0]      action_index,
    input  logic [bmea_pkg::RAW_W-1:0]          bind_mask,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bmea_pkg::LEVEL_W-1:0]        level_first,
    output logic [bmea_pkg::LEVEL_W-1:0]        level_second,
    output logic [bmea_pkg::HIT_COUNT-1:0]      hits_first,
    output logic [bmea_pkg::HIT_COUNT-1:0]      hits_second,
    output logic [bmea_pkg::COUNT_W-1:0]        coin_count,
    output logic [bmea_pkg::COUNT_W-1:0]        test_count
);
    import bmea_pkg::*;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [1:0]            func_reg;
    logic                  port_reg;
    logic                  sample_valid_reg;
    logic [RAW_W-1:0]      raw_reg;
    logic [ACT_IDX_W-1:0]  action_reg;
    logic [RAW_W-1:0]      mask_reg;

    logic                  in_accept;
    logic                  out_free;
    logic                  s1_fire;
    logic                  do_consume;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [LEVEL_W-1:0]    level_first_reg;
    logic [LEVEL_W-1:0]    level_second_reg;
    logic [HIT_COUNT-1:0]  hits_first_reg;
    logic [HIT_COUNT-1:0]  hits_second_reg;
    logic [COUNT_W-1:0]    coin_count_reg;
    logic [COUNT_W-1:0]    test_count_reg;

    logic [LEVEL_W-1:0]    level_arr [MAX_PORTS];
    logic [HIT_COUNT-1:0]  hits_arr [MAX_PORTS];
    logic [ADD_W-1:0]      coin_arr [MAX_PORTS];
    logic [ADD_W-1:0]      test_arr [MAX_PORTS];
    logic [ADD_W-1:0]      coin_add;
    logic [ADD_W-1:0]      test_add;
    logic [COUNT_W-1:0]    coin_now;
    logic [COUNT_W-1:0]    test_now;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire = s1_valid_reg && (func_reg != FUNC_CONSUME || out_free);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_accept = in_valid && !in_stall;
    assign do_consume = s1_fire && func_reg == FUNC_CONSUME;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg <= func;
            port_reg <= port;
            sample_valid_reg <= sample_valid;
            raw_reg <= raw_buttons;
            action_reg <= action_index;
            mask_reg <= bind_mask;
        end
    end

    for (genvar p = 0; p < MAX_PORTS; p++)
    begin : g_port
        if (p < PORT_COUNT)
        begin : g_live
            bmea_ctl_t              ctl;
            logic [ACTION_COUNT-1:0] level_full;

            assign ctl.sample = s1_fire && func_reg == FUNC_SAMPLE && port_reg == 1'(p);
            assign ctl.write = s1_fire && func_reg == FUNC_WRITE && port_reg == 1'(p);
            assign ctl.consume = do_consume;

            bmea_port_unit #(
                .ACTION_COUNT(ACTION_COUNT)
            ) u_port (
                .clk(clk),
                .rst_n(rst_n),
                .ctl(ctl),
                .sample_valid(sample_valid_reg),
                .raw_buttons(raw_reg),
                .action_index(action_reg),
                .bind_mask(mask_reg),
                .level(level_full),
                .hits(hits_arr[p]),
                .coin_add(coin_arr[p]),
                .test_add(test_arr[p])
            );

            assign level_arr[p] = level_full[LEVEL_W-1:0];
        end
        else
        begin : g_absent
            assign level_arr[p] = '0;
            assign hits_arr[p] = '0;
            assign coin_arr[p] = '0;
            assign test_arr[p] = '0;
        end
    end

    always_comb
    begin
        coin_add = '0;
        test_add = '0;
        for (int p = 0; p < MAX_PORTS; p++)
        begin
            coin_add = coin_add | coin_arr[p];
            test_add = test_add | test_arr[p];
        end
    end

    bmea_sat_counter u_coin (
        .clk(clk),
        .rst_n(rst_n),
        .clear(do_consume),
        .add(coin_add),
        .count(coin_now)
    );

    bmea_sat_counter u_test (
        .clk(clk),
        .rst_n(rst_n),
        .clear(do_consume),
        .add(test_add),
        .count(test_now)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (do_consume)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_consume)
        begin
            level_first_reg <= level_arr[0];
            level_second_reg <= level_arr[1];
            hits_first_reg <= hits_arr[0];
            hits_second_reg <= hits_arr[1];
            coin_count_reg <= coin_now;
            test_count_reg <= test_now;
        end
    end

    assign out_valid = out_valid_reg;
    assign level_first = level_first_reg;
    assign level_second = level_second_reg;
    assign hits_first = hits_first_reg;
    assign hits_second = hits_second_reg;
    assign coin_count = coin_count_reg;
    assign test_count = test_count_reg;

endmodule

// File: src/bmea_port_unit.sv
module bmea_port_unit #(
    parameter int ACTION_COUNT = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bmea_pkg::bmea_ctl_t                 ctl,
    input  logic                                sample_valid,
    input  logic [bmea_pkg::RAW_W-1:0]          raw_buttons,
    input  logic [bmea_pkg::ACT_IDX_W-1:0]      action_index,
    input  logic [bmea_pkg::RAW_W-1:0]          bind_mask,
    output logic [ACTION_COUNT-1:0]             level,
    output logic [bmea_pkg::HIT_COUNT-1:0]      hits,
    output logic [bmea_pkg::ADD_W-1:0]          coin_add,
    output logic [bmea_pkg::ADD_W-1:0]          test_add
);
    import bmea_pkg::*;

    logic [RAW_W-1:0]        binding_reg [ACTION_COUNT];
    logic [RAW_W-1:0]        prev_raw_reg;
    logic [RAW_W-1:0]        prev_raw_next;
    logic [ACTION_COUNT-1:0] live_reg;
    logic [ACTION_COUNT-1:0] live_next;
    logic [ACTION_COUNT-1:0] sticky_reg;
    logic [ACTION_COUNT-1:0] sticky_next;
    logic [HIT_COUNT-1:0]    hits_reg;
    logic [HIT_COUNT-1:0]    hits_next;
    logic [RAW_W-1:0]        raw_eff;
    logic [RAW_W-1:0]        rising;
    logic [ACTION_COUNT-1:0] lvl;
    logic [HIT_COUNT-1:0]    hit_rise;

    for (genvar a = 0; a < ACTION_COUNT; a++)
    begin : g_bind
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                binding_reg[a] <= default_binding(ACT_IDX_W'(a));
            end
            else if (ctl.write && action_index == ACT_IDX_W'(a))
            begin
                binding_reg[a] <= bind_mask;
            end
        end
        assign lvl[a] = |(binding_reg[a] & raw_eff);
    end

    for (genvar h = 0; h < HIT_COUNT; h++)
    begin : g_hit
        assign hit_rise[h] = |(rising & binding_reg[h]);
    end

    assign raw_eff = sample_valid ? raw_buttons : prev_raw_reg;
    assign rising = raw_eff & ~prev_raw_reg;

    always_comb
    begin
        prev_raw_next = prev_raw_reg;
        live_next = live_reg;
        sticky_next = sticky_reg;
        hits_next = hits_reg;
        if (ctl.sample)
        begin
            prev_raw_next = raw_eff;
            live_next = lvl;
            sticky_next = sticky_reg | lvl;
            hits_next = hits_reg | hit_rise;
        end
        else if (ctl.consume)
        begin
            sticky_next = '0;
            hits_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg <= '0;
            live_reg <= '0;
            sticky_reg <= '0;
            hits_reg <= '0;
        end
        else
        begin
            prev_raw_reg <= prev_raw_next;
            live_reg <= live_next;
            sticky_reg <= sticky_next;
            hits_reg <= hits_next;
        end
    end

    assign level = live_reg | sticky_reg;
    assign hits = hits_reg;
    assign coin_add = ctl.sample ? popcount32(rising & binding_reg[ACT_COIN]) : '0;
    assign test_add = ctl.sample ? popcount32(rising & binding_reg[ACT_TEST]) : '0;

endmodule

// File: src/bmea_sat_counter.sv
module bmea_sat_counter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            clear,
    input  logic [bmea_pkg::ADD_W-1:0]      add,
    output logic [bmea_pkg::COUNT_W-1:0]    count
);
    import bmea_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W:0]   sum;

    assign sum = {1'b0, count_reg} + (COUNT_W + 1)'(add);

    always_comb
    begin
        if (clear)
        begin
            count_next = '0;
        end
        else if (sum > (COUNT_W + 1)'(COUNT_MAX))
        begin
            count_next = COUNT_MAX;
        end
        else
        begin
            count_next = sum[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

// File: src/bmea_checker.sv
`include "button_map_edge_accumulator_macros.svh"

module bmea_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic [1:0]                          func,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [bmea_pkg::LEVEL_W-1:0]        level_first,
    input logic [bmea_pkg::LEVEL_W-1:0]        level_second,
    input logic [bmea_pkg::HIT_COUNT-1:0]      hits_first,
    input logic [bmea_pkg::HIT_COUNT-1:0]      hits_second,
    input logic [bmea_pkg::COUNT_W-1:0]        coin_count,
    input logic [bmea_pkg::COUNT_W-1:0]        test_count
);
    import bmea_pkg::*;

    logic                                              consume_beat;
    logic                                              out_held;
    logic [2*LEVEL_W+2*HIT_COUNT+2*COUNT_W-1:0]        out_beat;

    assign consume_beat = in_valid && !in_stall && func == FUNC_CONSUME;
    assign out_held = out_valid && out_stall;
    assign out_beat = {level_first, level_second, hits_first, hits_second,
                       coin_count, test_count};

    // A stalled result beat keeps its valid and every field.
    `BMEA_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_beat), "stalled beat changed")

    // A fresh result comes from an accepted consume beat that has passed through the input register.
    `BMEA_ASSERT_NOW(a_out_origin, $rose(out_valid), $past(consume_beat, 2), "result without consume")

    // The input side only stalls behind a stalled result.
    `BMEA_ASSERT_NOW(a_stall_cause, in_stall, out_held, "input stalled while the output was free")

endmodule

bind button_map_edge_accumulator bmea_checker u_bmea_checker (.*);

// File: sim/bmea_snapshot_checker.sv
`timescale 1ns / 1ps

module bmea_snapshot_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [1:0]                          func,
    input  logic                                port,
    input  logic                                sample_valid,
    input  logic [bmea_pkg::RAW_W-1:0]          raw_buttons,
    input  logic [bmea_pkg::ACT_IDX_W-1:0]      action_index,
    input  logic [bmea_pkg::RAW_W-1:0]          bind_mask,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [bmea_pkg::LEVEL_W-1:0]        level_first,
    input  logic [bmea_pkg::LEVEL_W-1:0]        level_second,
    input  logic [bmea_pkg::HIT_COUNT-1:0]      hits_first,
    input  logic [bmea_pkg::HIT_COUNT-1:0]      hits_second,
    input  logic [bmea_pkg::COUNT_W-1:0]        coin_count,
    input  logic [bmea_pkg::COUNT_W-1:0]        test_count,
    output int                                  errors,
    output int                                  pending
);

    import bmea_pkg::*;

    typedef struct packed {
        logic [LEVEL_W-1:0]   level_first;
        logic [LEVEL_W-1:0]   level_second;
        logic [HIT_COUNT-1:0] hits_first;
        logic [HIT_COUNT-1:0] hits_second;
        logic [COUNT_W-1:0]   coin_count;
        logic [COUNT_W-1:0]   test_count;
    } snapshot_t;

    logic [RAW_W-1:0]     button_mask [MAX_PORTS][LEVEL_W];
    logic [RAW_W-1:0]     last_raw [MAX_PORTS];
    logic [LEVEL_W-1:0]   live [MAX_PORTS];
    logic [LEVEL_W-1:0]   sticky [MAX_PORTS];
    logic [HIT_COUNT-1:0] hit_flags [MAX_PORTS];
    logic [COUNT_W-1:0]   coin_total;
    logic [COUNT_W-1:0]   test_total;
    snapshot_t            snapshot_q [$];
    snapshot_t            observed;

    assign observed = {level_first, level_second, hits_first, hits_second,
                       coin_count, test_count};

    function automatic logic [COUNT_W-1:0] add_capped(input logic [COUNT_W-1:0] acc,
                                                      input int unsigned n);
        int unsigned s;
        s = acc + n;
        if (s > COUNT_MAX)
        begin
            return COUNT_MAX;
        end
        return COUNT_W'(s);
    endfunction

    task automatic restore_defaults();
        for (int p = 0; p < MAX_PORTS; p++)
        begin
            button_mask[p][ACT_HIT_SL] = BTN_LEFT | BTN_UP | BTN_L1 | BTN_L2;
            button_mask[p][ACT_HIT_CL] = BTN_RIGHT | BTN_DPAD_DOWN;
            button_mask[p][ACT_HIT_CR] = BTN_SQUARE | BTN_CROSS;
            button_mask[p][ACT_HIT_SR] = BTN_TRIANGLE | BTN_CIRCLE | BTN_R1 | BTN_R2;
            button_mask[p][ACT_ENTER] = BTN_START;
            button_mask[p][ACT_SERVICE] = BTN_R3;
            button_mask[p][ACT_TEST] = BTN_SELECT;
            button_mask[p][ACT_COIN] = BTN_L3;
            button_mask[p][ACT_UP] = BTN_UP;
            button_mask[p][ACT_DOWN] = BTN_DPAD_DOWN;
            last_raw[p] = '0;
            live[p] = '0;
            sticky[p] = '0;
            hit_flags[p] = '0;
        end
        coin_total = '0;
        test_total = '0;
    endtask

    task automatic apply_pad_sample(input int p, input logic fresh,
                                    input logic [RAW_W-1:0] raw_in);
        logic [RAW_W-1:0]   cur;
        logic [RAW_W-1:0]   rising;
        logic [LEVEL_W-1:0] lvl;
        cur = fresh ? raw_in : last_raw[p];
        rising = cur & ~last_raw[p];
        last_raw[p] = cur;
        lvl = '0;
        for (int a = 0; a < LEVEL_W; a++)
        begin
            lvl[a] = |(button_mask[p][a] & cur);
        end
        live[p] = lvl;
        sticky[p] = sticky[p] | lvl;
        for (int a = 0; a < HIT_COUNT; a++)
        begin
            if (|(rising & button_mask[p][a]))
            begin
                hit_flags[p][a] = 1'b1;
            end
        end
        coin_total = add_capped(coin_total, $countones(rising & button_mask[p][ACT_COIN]));
        test_total = add_capped(test_total, $countones(rising & button_mask[p][ACT_TEST]));
    endtask

    function automatic snapshot_t take_snapshot();
        snapshot_t s;
        s.level_first = live[0] | sticky[0];
        s.level_second = live[1] | sticky[1];
        s.hits_first = hit_flags[0];
        s.hits_second = hit_flags[1];
        s.coin_count = coin_total;
        s.test_count = test_total;
        for (int p = 0; p < MAX_PORTS; p++)
        begin
            sticky[p] = '0;
            hit_flags[p] = '0;
        end
        coin_total = '0;
        test_total = '0;
        return s;
    endfunction

    function automatic int field_check(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    function automatic int fields_differ(input snapshot_t want, input snapshot_t got);
        int n;
        n = field_check("level_first", 32'(want.level_first), 32'(got.level_first));
        n += field_check("level_second", 32'(want.level_second), 32'(got.level_second));
        n += field_check("hits_first", 32'(want.hits_first), 32'(got.hits_first));
        n += field_check("hits_second", 32'(want.hits_second), 32'(got.hits_second));
        n += field_check("coin_count", 32'(want.coin_count), 32'(got.coin_count));
        n += field_check("test_count", 32'(want.test_count), 32'(got.test_count));
        return n;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restore_defaults();
            snapshot_q.delete();
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (snapshot_q.size() == 0)
                begin
                    $display("%0t: snapshot beat expected none, got %h", $time, observed);
                    errors <= errors + 1;
                end
                else if (fields_differ(snapshot_q.pop_front(), observed) != 0)
                begin
                    errors <= errors + 1;
                end
            end
            if (in_valid && !in_stall)
            begin
                case (func)
                    FUNC_SAMPLE:
                    begin
                        apply_pad_sample(port, sample_valid, raw_buttons);
                    end
                    FUNC_CONSUME:
                    begin
                        snapshot_q.push_back(take_snapshot());
                    end
                    FUNC_WRITE:
                    begin
                        if (action_index < LEVEL_W)
                        begin
                            button_mask[port][action_index] = bind_mask;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            pending <= snapshot_q.size();
        end
    end

endmodule

// File: sim/button_map_edge_accumulator_test.sv
`timescale 1ns / 1ps

module button_map_edge_accumulator_test;

    import bmea_pkg::*;

    localparam logic [1:0]       FUNC_UNUSED = 2'd3;
    localparam logic [RAW_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [RAW_W-1:0] NO_BUTTONS = 32'h0000_0000;
    localparam logic [RAW_W-1:0] DEFAULT_BUTTONS = 32'h00FF_00FF;
    localparam int               PRESSURE_CYCLES = 300;
    localparam int               SATURATION_PAIRS = 16;
    localparam int               PHASE_ITEMS = 400;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             func = FUNC_SAMPLE;
    logic                   port = 1'b0;
    logic                   sample_valid = 1'b0;
    logic [RAW_W-1:0]       raw_buttons = '0;
    logic [ACT_IDX_W-1:0]   action_index = '0;
    logic [RAW_W-1:0]       bind_mask = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [LEVEL_W-1:0]     level_first;
    logic [LEVEL_W-1:0]     level_second;
    logic [HIT_COUNT-1:0]   hits_first;
    logic [HIT_COUNT-1:0]   hits_second;
    logic [COUNT_W-1:0]     coin_count;
    logic [COUNT_W-1:0]     test_count;
    int                     errors;
    int                     pending;
    int                     send_idle_pct = 0;
    int                     recv_stall_pct = 0;
    logic                   pressure_go = 1'b0;
    logic                   hold_off = 1'b0;

    button_map_edge_accumulator u_dut (.*);

    bmea_snapshot_checker u_checker (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("[button_map_edge_accumulator] ERROR");
        $finish;
    end

    task automatic offer(input logic [1:0] f, input logic p, input logic fresh,
                         input logic [RAW_W-1:0] raw, input logic [ACT_IDX_W-1:0] act,
                         input logic [RAW_W-1:0] mask);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        port <= p;
        sample_valid <= fresh;
        raw_buttons <= raw;
        action_index <= act;
        bind_mask <= mask;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic offer_random(input int consume_pct);
        int                     pick;
        logic [RAW_W-1:0]       raw;
        logic [RAW_W-1:0]       mask;
        logic [ACT_IDX_W-1:0]   act;
        logic [1:0]             f;
        pick = $urandom_range(99);
        case ($urandom_range(3))
            0: raw = $urandom;
            1: raw = $urandom & $urandom & DEFAULT_BUTTONS;
            2: raw = 32'h1 << $urandom_range(31);
            default: raw = ($urandom_range(1) == 0) ? NO_BUTTONS : ALL_ONES;
        endcase
        case ($urandom_range(3))
            0: mask = $urandom;
            1: mask = 32'h1 << $urandom_range(31);
            2: mask = $urandom & DEFAULT_BUTTONS;
            default: mask = ($urandom_range(1) == 0) ? NO_BUTTONS : ALL_ONES;
        endcase
        if ($urandom_range(5) == 0)
        begin
            act = ACT_IDX_W'($urandom_range(15, 10));
        end
        else
        begin
            act = ACT_IDX_W'($urandom_range(9));
        end
        if (pick < consume_pct)
        begin
            f = FUNC_CONSUME;
        end
        else if (pick < consume_pct + 6)
        begin
            f = FUNC_WRITE;
        end
        else if (pick < consume_pct + 8)
        begin
            f = FUNC_UNUSED;
        end
        else
        begin
            f = FUNC_SAMPLE;
        end
        offer(f, 1'($urandom_range(1)), $urandom_range(4) != 0, raw, act, mask);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(FUNC_CONSUME, 1'b0, 1'b0, NO_BUTTONS, ACT_HIT_SL, NO_BUTTONS);
        offer(FUNC_SAMPLE, 1'b0, 1'b1, ALL_ONES, ACT_HIT_SL, NO_BUTTONS);
        offer(FUNC_SAMPLE, 1'b1, 1'b1, ALL_ONES, ACT_HIT_SL, NO_BUTTONS);
        offer(FUNC_CONSUME, 1'b0, 1'b0, NO_BUTTONS, ACT_HIT_SL, NO_BUTTONS);
        offer(FUNC_SAMPLE, 1'b0, 1'b0, NO_BUTTONS, ACT_HIT_SL, NO_BUTTONS);
        offer(FUNC_CONSUME, 1'b1, 1'b1, ALL_ONES, ACT_DOWN, ALL_ONES);
        offer(FUNC_SAMPLE, 1'b0, 1'b1, NO_BUTTONS, ACT_HIT_SL, NO_BUTTONS);
        offer(FUNC_SAMPLE, 1'b0, 1'b1, BTN_UP, ACT_HIT_SL, NO_BUTTONS);
        offer(FUNC_SAMPLE, 1'b0, 1'b1, NO_BUTTONS, ACT_HIT_SL, NO_BUTTONS);
        offer(FUNC_SAMPLE, 1'b0, 1'b1, BTN_UP | BTN_L3 | BTN_SELECT, ACT_HIT_SL, NO_BUTTONS);
        offer(FUNC_CONSUME, 1'b0, 1'b0, NO_BUTTONS, ACT_HIT_SL, NO_BUTTONS);
        offer(FUNC_WRITE, 1'b1, 1'b0, NO_BUTTONS, ACT_COIN, ALL_ONES);
        offer(FUNC_WRITE, 1'b1, 1'b0, NO_BUTTONS, ACT_TEST, 32'hFFFF_0000);
        offer(FUNC_SAMPLE, 1'b1, 1'b1, NO_BUTTONS, ACT_HIT_SL, NO_BUTTONS);
        offer(FUNC_SAMPLE, 1'b1, 1'b1, ALL_ONES, ACT_HIT_SL, NO_BUTTONS);
        offer(FUNC_CONSUME, 1'b1, 1'b0, NO_BUTTONS, ACT_HIT_SL, NO_BUTTONS);
        offer(FUNC_WRITE, 1'b0, 1'b1, ALL_ONES, 4'd15, ALL_ONES);
        offer(FUNC_WRITE, 1'b0, 1'b0, NO_BUTTONS, ACT_HIT_CR, NO_BUTTONS);
        offer(FUNC_UNUSED, 1'b1, 1'b1, ALL_ONES, 4'd10, ALL_ONES);
        offer(FUNC_SAMPLE, 1'b0, 1'b1, NO_BUTTONS, ACT_HIT_SL, NO_BUTTONS);
        offer(FUNC_SAMPLE, 1'b0, 1'b1, BTN_SQUARE | BTN_CROSS | BTN_R2, ACT_HIT_SL, NO_BUTTONS);
        offer(FUNC_CONSUME, 1'b0, 1'b0, NO_BUTTONS, ACT_HIT_SL, NO_BUTTONS);

        offer(FUNC_WRITE, 1'b0, 1'b0, NO_BUTTONS, ACT_COIN, ALL_ONES);
        offer(FUNC_WRITE, 1'b0, 1'b0, NO_BUTTONS, ACT_TEST, ALL_ONES);
        offer(FUNC_SAMPLE, 1'b0, 1'b1, NO_BUTTONS, ACT_HIT_SL, NO_BUTTONS);
        offer(FUNC_CONSUME, 1'b0, 1'b0, NO_BUTTONS, ACT_HIT_SL, NO_BUTTONS);
        for (int i = 0; i < SATURATION_PAIRS; i++)
        begin
            offer(FUNC_SAMPLE, 1'b0, 1'b1, ALL_ONES, ACT_HIT_SL, NO_BUTTONS);
            offer(FUNC_SAMPLE, 1'b0, 1'b1, NO_BUTTONS, ACT_HIT_SL, NO_BUTTONS);
        end
        offer(FUNC_CONSUME, 1'b0, 1'b0, NO_BUTTONS, ACT_HIT_SL, NO_BUTTONS);
        offer(FUNC_WRITE, 1'b0, 1'b0, NO_BUTTONS, ACT_COIN, BTN_L3);
        offer(FUNC_WRITE, 1'b0, 1'b0, NO_BUTTONS, ACT_TEST, BTN_SELECT);
        offer(FUNC_WRITE, 1'b1, 1'b0, NO_BUTTONS, ACT_COIN, BTN_L3);
        offer(FUNC_WRITE, 1'b1, 1'b0, NO_BUTTONS, ACT_TEST, BTN_SELECT);

        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            offer_random(15);
        end

        pressure_go = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            offer_random(50);
        end

        for (int phase = 1; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 64 : (phase == 2) ? 0 : 31;
            recv_stall_pct = (phase == 1) ? 0 : (phase == 2) ? 64 : 31;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                offer_random(15);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("[button_map_edge_accumulator] OK");
        end
        else
        begin
            $display("[button_map_edge_accumulator] ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/bmea_pkg.sv
src/bmea_port_unit.sv
src/bmea_sat_counter.sv
src/button_map_edge_accumulator.sv
src/bmea_checker.sv
sim/bmea_snapshot_checker.sv
sim/button_map_edge_accumulator_test.sv
